FILE: hw/rtl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int unsigned PRESCALE_W = 10;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [1:0] ACTION_TICK        = 2'd0;
    localparam logic [1:0] ACTION_CLEAR_WATCH = 2'd1;
    localparam logic [1:0] ACTION_RESTART     = 2'd2;

    localparam logic CFG_TICKS_PER_SECOND = 1'b0;
    localparam logic CFG_CHASER_PERIOD    = 1'b1;

    localparam logic [9:0] TICKS_PER_SECOND_RESET = 10'd200;
    localparam logic [9:0] CHASER_PERIOD_RESET    = 10'd100;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;
    localparam logic [4:0] RESTART_HOUR       = 5'd12;

    localparam logic [1:0] CHASER_STEP_0 = 2'd0;
    localparam logic [1:0] CHASER_STEP_1 = 2'd1;
    localparam logic [1:0] CHASER_STEP_2 = 2'd2;

    localparam logic [7:0] LED_STEP_0 = 8'hfc;
    localparam logic [7:0] LED_STEP_1 = 8'hfa;
    localparam logic [7:0] LED_STEP_2 = 8'hf6;
    localparam logic [7:0] LED_NORMAL = 8'hfe;
    localparam logic [7:0] LED_OFF    = 8'hff;

    typedef struct packed {
        logic [1:0] action;
        logic       stopwatch_run;
        logic       alarm_active;
        logic       power_on;
    } t_item;

    typedef struct packed {
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [5:0] clock_second;
        logic [4:0] watch_hour;
        logic [5:0] watch_minute;
        logic [5:0] watch_second;
        logic [7:0] led_pattern;
    } t_result;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_hms;

    typedef struct packed {
        logic tick;
        logic load;
    } t_hms_ctrl;

endpackage

FILE: hw/rtl/tick_clock_stopwatch_led_chaser.sv
`timescale 1ns / 1ps

// Time-of-day clock, stopwatch and alarm LED chaser driven by tick transactions.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one action per
// transaction: a tick, a stopwatch clear or a clock restart at 12:00:00, along
// with the stopwatch run, alarm and power levels.
// Each input transaction yields exactly one output transaction on o_out_valid,
// i_out_stall and o_out_data, holding the time of day, the stopwatch time and
// the LED byte as they stand after that action.
// o_out_valid rises in the cycle after acceptance. Throughput is one transaction
// per cycle while the receiver does not stall: the counter update is a single
// registered pass from the state registers into the output register.
// While the receiver stalls, the output register holds its transaction and
// o_in_stall is raised, so no further input is taken until the result moves.
// The configuration port writes ticks_per_second (index 0) and chaser_period
// (index 1); the user must use it only while the block is idle (unchecked).
// Synchronous reset sets the clock to 12:00:00, the stopwatch to 00:00:00,
// the prescalers and chaser to zero, restores the register defaults and
// empties the output register.

module tick_clock_stopwatch_led_chaser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tccs_pkg::t_item                     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tccs_pkg::t_result                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [tccs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [tccs_pkg::PRESCALE_W-1:0] r_ticks_per_second;
    logic [tccs_pkg::PRESCALE_W-1:0] r_chaser_period;
    logic [tccs_pkg::PRESCALE_W-1:0] r_chaser_count;
    logic [tccs_pkg::PRESCALE_W-1:0] n_chaser_count;
    logic [1:0]                      r_chaser_step;
    logic [1:0]                      n_chaser_step;
    logic                            r_out_valid;
    tccs_pkg::t_result               r_out_data;
    tccs_pkg::t_result               n_out_data;
    logic                            w_accept;
    logic                            w_tick;
    logic [tccs_pkg::PRESCALE_W:0]   w_chaser_sum;
    logic [7:0]                      w_led;
    tccs_pkg::t_hms_ctrl             w_clock_ctrl;
    tccs_pkg::t_hms_ctrl             w_watch_ctrl;
    tccs_pkg::t_hms                  w_clock_next;
    tccs_pkg::t_hms                  w_watch_next;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_tick     = w_accept && (i_in_data.action == tccs_pkg::ACTION_TICK);

    assign w_clock_ctrl.tick = w_tick;
    assign w_clock_ctrl.load = w_accept && (i_in_data.action == tccs_pkg::ACTION_RESTART);
    assign w_watch_ctrl.tick = w_tick && i_in_data.stopwatch_run;
    assign w_watch_ctrl.load = w_accept
                               && (i_in_data.action == tccs_pkg::ACTION_CLEAR_WATCH);

    tccs_hms_counter u_clock (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_clock_ctrl),
        .i_limit       (r_ticks_per_second),
        .i_preset_hour (tccs_pkg::RESTART_HOUR),
        .o_next        (w_clock_next)
    );

    tccs_hms_counter u_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_watch_ctrl),
        .i_limit       (r_ticks_per_second),
        .i_preset_hour (5'd0),
        .o_next        (w_watch_next)
    );

    assign w_chaser_sum = {1'b0, r_chaser_count} + {{tccs_pkg::PRESCALE_W{1'b0}}, 1'b1};

    always_comb begin
        n_chaser_count = r_chaser_count;
        n_chaser_step  = r_chaser_step;
        if (w_accept) begin
            if (!i_in_data.alarm_active
                    || (i_in_data.action == tccs_pkg::ACTION_RESTART)) begin
                n_chaser_count = '0;
                n_chaser_step  = tccs_pkg::CHASER_STEP_0;
            end else if (i_in_data.action == tccs_pkg::ACTION_TICK) begin
                if (w_chaser_sum >= {1'b0, r_chaser_period}) begin
                    n_chaser_count = '0;
                    if (r_chaser_step >= tccs_pkg::CHASER_STEP_2) begin
                        n_chaser_step = tccs_pkg::CHASER_STEP_0;
                    end else begin
                        n_chaser_step = r_chaser_step + 2'd1;
                    end
                end else begin
                    n_chaser_count = w_chaser_sum[tccs_pkg::PRESCALE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        if (!i_in_data.power_on) begin
            w_led = tccs_pkg::LED_OFF;
        end else if (!i_in_data.alarm_active) begin
            w_led = tccs_pkg::LED_NORMAL;
        end else begin
            unique case (n_chaser_step)
                tccs_pkg::CHASER_STEP_0: w_led = tccs_pkg::LED_STEP_0;
                tccs_pkg::CHASER_STEP_1: w_led = tccs_pkg::LED_STEP_1;
                tccs_pkg::CHASER_STEP_2: w_led = tccs_pkg::LED_STEP_2;
                default:                 w_led = tccs_pkg::LED_NORMAL;
            endcase
        end
    end

    always_comb begin
        n_out_data.clock_hour   = w_clock_next.hour;
        n_out_data.clock_minute = w_clock_next.minute;
        n_out_data.clock_second = w_clock_next.second;
        n_out_data.watch_hour   = w_watch_next.hour;
        n_out_data.watch_minute = w_watch_next.minute;
        n_out_data.watch_second = w_watch_next.second;
        n_out_data.led_pattern  = w_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second <= tccs_pkg::TICKS_PER_SECOND_RESET;
            r_chaser_period    <= tccs_pkg::CHASER_PERIOD_RESET;
            r_chaser_count     <= '0;
            r_chaser_step      <= tccs_pkg::CHASER_STEP_0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tccs_pkg::CFG_TICKS_PER_SECOND: r_ticks_per_second <= i_cfg_data;
                    tccs_pkg::CFG_CHASER_PERIOD:    r_chaser_period    <= i_cfg_data;
                    default:                        r_chaser_period    <= r_chaser_period;
                endcase
            end
            r_chaser_count <= n_chaser_count;
            r_chaser_step  <= n_chaser_step;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/tccs_hms_counter.sv
`timescale 1ns / 1ps

module tccs_hms_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tccs_pkg::t_hms_ctrl                 i_ctrl,
    input  logic [tccs_pkg::PRESCALE_W-1:0]     i_limit,
    input  logic [4:0]                          i_preset_hour,
    output tccs_pkg::t_hms                      o_next
);

    logic [tccs_pkg::PRESCALE_W-1:0] r_prescale;
    logic [tccs_pkg::PRESCALE_W-1:0] n_prescale;
    tccs_pkg::t_hms                  r_time;
    tccs_pkg::t_hms                  n_time;
    logic [tccs_pkg::PRESCALE_W:0]   w_sum;
    logic                            w_roll;

    assign w_sum = {1'b0, r_prescale} + {{tccs_pkg::PRESCALE_W{1'b0}}, 1'b1};

    always_comb begin
        n_prescale = r_prescale;
        w_roll     = 1'b0;
        if (i_ctrl.tick) begin
            if (w_sum >= {1'b0, i_limit}) begin
                n_prescale = '0;
                w_roll     = 1'b1;
            end else begin
                n_prescale = w_sum[tccs_pkg::PRESCALE_W-1:0];
            end
        end
    end

    always_comb begin
        n_time = r_time;
        if (i_ctrl.load) begin
            n_time.hour   = i_preset_hour;
            n_time.minute = '0;
            n_time.second = '0;
        end else if (w_roll) begin
            if (r_time.second + 6'd1 >= tccs_pkg::SECONDS_PER_MINUTE) begin
                n_time.second = '0;
                if (r_time.minute + 6'd1 >= tccs_pkg::MINUTES_PER_HOUR) begin
                    n_time.minute = '0;
                    if (r_time.hour + 5'd1 >= tccs_pkg::HOURS_PER_DAY) begin
                        n_time.hour = '0;
                    end else begin
                        n_time.hour = r_time.hour + 5'd1;
                    end
                end else begin
                    n_time.minute = r_time.minute + 6'd1;
                end
            end else begin
                n_time.second = r_time.second + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale    <= '0;
            r_time.hour   <= i_preset_hour;
            r_time.minute <= '0;
            r_time.second <= '0;
        end else begin
            r_prescale <= n_prescale;
            r_time     <= n_time;
        end
    end

    assign o_next = n_time;

endmodule

FILE: hw/rtl/tccs_checker.sv
`timescale 1ns / 1ps

module tccs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  tccs_pkg::t_result o_out_data
);

    // Every accepted input transaction shows up as a result in the next cycle.
    a_accept_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // Input is only held off while a result waits on a stalled receiver.
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a pending result");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Times in a result stay within a 24 hour day.
    a_time_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.clock_hour < 5'd24 && o_out_data.clock_minute < 6'd60
                         && o_out_data.clock_second < 6'd60
                         && o_out_data.watch_hour < 5'd24
                         && o_out_data.watch_minute < 6'd60
                         && o_out_data.watch_second < 6'd60))
        else $error("time field out of range");

endmodule

bind tick_clock_stopwatch_led_chaser tccs_checker u_tccs_checker (.*);
